FILE: src/rgbhsi_pkg.sv
// Package for the RGB to HSI converter: pixel and result types, fixed-point
// constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
package rgbhsi_pkg;

    // Output formats
    localparam int HUE_FRAC_BITS = 6;   // hue fraction bits, 0..6
    localparam int SAT_BITS      = 16;  // saturation fraction bits, 8..23

    // Hue datapath
    localparam int ANG_BITS     = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int DW           = 32;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;
    localparam logic signed [DW-1:0] DEG90_Q20  = 32'sd94371840;
    localparam logic signed [DW-1:0] DEG180_Q20 = 32'sd188743680;
    localparam int HUE_SHIFT = ANG_BITS - HUE_FRAC_BITS;
    localparam logic signed [DW-1:0] HUE_HALF = DW'((2 ** HUE_SHIFT) / 2);
    localparam logic [19:0] HUE_FULL = 20'(360 * (2 ** HUE_FRAC_BITS));

    // Saturation divider: one quotient bit per stage
    localparam int DIV_STEPS = SAT_BITS + 1;
    localparam int NUM_W     = SAT_BITS + 10;
    localparam logic [DIV_STEPS-1:0] SAT_MAX =
        DIV_STEPS'((SAT_BITS > 16) ? 65535 : (2 ** SAT_BITS) - 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [9:0]  intensity_sum;
    } t_hsi;

    // atan(2^-i) in degrees, Q20
    function automatic logic signed [DW-1:0] atan_deg(input logic [4:0] i);
        logic signed [DW-1:0] v;
        case (i)
            5'd0:    v = 32'sd47185920;
            5'd1:    v = 32'sd27855475;
            5'd2:    v = 32'sd14718068;
            5'd3:    v = 32'sd7471121;
            5'd4:    v = 32'sd3750058;
            5'd5:    v = 32'sd1876857;
            5'd6:    v = 32'sd938658;
            5'd7:    v = 32'sd469357;
            5'd8:    v = 32'sd234682;
            5'd9:    v = 32'sd117342;
            5'd10:   v = 32'sd58671;
            5'd11:   v = 32'sd29335;
            5'd12:   v = 32'sd14668;
            5'd13:   v = 32'sd7334;
            5'd14:   v = 32'sd3667;
            5'd15:   v = 32'sd1833;
            5'd16:   v = 32'sd917;
            5'd17:   v = 32'sd458;
            5'd18:   v = 32'sd229;
            5'd19:   v = 32'sd115;
            5'd20:   v = 32'sd57;
            5'd21:   v = 32'sd29;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/rgb_to_hsi_converter.sv
// RGB to HSI converter top level: pipelined CORDIC hue and restoring divider
// saturation, one pixel per clock. Depends on rgbhsi_pkg.
`timescale 1ns / 1ps
//
//  channel  | handshake      | payload
//  ---------+----------------+-----------------------------------------
//  pixel in | start / busy   | i_pixel (red, green, blue)
//  result   | o_done strobe  | o_hsi (hue, saturation, intensity_sum)
//
//  A pixel enters on every clock with start high; busy is always low.
//  The pipeline has an input stage, a pre-rotate stage, 24 CORDIC stages
//  (the first DIV_STEPS also run one divider quotient bit each) and an output stage.
//  Synchronous active-low reset clears the valid bits only.
//  The receiver cannot stall, so the pipeline never holds.
module rgb_to_hsi_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsi_pkg::t_rgb    i_pixel,
    output logic                o_done,
    output rgbhsi_pkg::t_hsi    o_hsi
);
    import rgbhsi_pkg::*;

    localparam int N = CORDIC_STEPS;

    // input stage registers
    logic              r_p_valid;
    logic signed [10:0] r_p_diff;
    logic [7:0]        r_p_d;
    logic [7:0]        r_p_mn;
    logic [9:0]        r_p_sum;
    logic              r_p_grey;
    logic              r_p_bg;

    // pipeline stage registers, index 0 is after pre-rotation
    logic                  r_v    [0:N];
    logic signed [DW-1:0]  r_x    [0:N];
    logic signed [DW-1:0]  r_y    [0:N];
    logic signed [DW-1:0]  r_acc  [0:N];
    logic [9:0]            r_rem  [0:N];
    logic [DIV_STEPS-1:0]  r_nlo  [0:N];
    logic [DIV_STEPS-1:0]  r_q    [0:N];
    logic [9:0]            r_sum  [0:N];
    logic                  r_grey [0:N];
    logic                  r_bg   [0:N];

    logic signed [DW-1:0]  n_x    [0:N];
    logic signed [DW-1:0]  n_y    [0:N];
    logic signed [DW-1:0]  n_acc  [0:N];
    logic [9:0]            n_rem  [0:N];
    logic [DIV_STEPS-1:0]  n_nlo  [0:N];
    logic [DIV_STEPS-1:0]  n_q    [0:N];

    // output registers
    logic   r_done;
    t_hsi   r_hsi;

    // input stage logic
    logic [7:0]        n_p_d;
    logic [7:0]        n_p_mn;
    logic signed [10:0] n_p_diff;
    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_p_d  = (i_pixel.green > i_pixel.blue) ? i_pixel.green - i_pixel.blue
                                                : i_pixel.blue - i_pixel.green;
        n_p_mn = i_pixel.red;
        if (i_pixel.green < n_p_mn) n_p_mn = i_pixel.green;
        if (i_pixel.blue < n_p_mn)  n_p_mn = i_pixel.blue;
        n_p_diff = $signed({2'b00, i_pixel.red, 1'b0}) - $signed({3'b000, i_pixel.green})
                   - $signed({3'b000, i_pixel.blue});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= accept;
        end
        r_p_diff <= n_p_diff;
        r_p_d    <= n_p_d;
        r_p_mn   <= n_p_mn;
        r_p_sum  <= 10'(i_pixel.red) + 10'(i_pixel.green) + 10'(i_pixel.blue);
        r_p_grey <= (i_pixel.red == i_pixel.green) && (i_pixel.green == i_pixel.blue);
        r_p_bg   <= i_pixel.blue > i_pixel.green;
    end

    logic signed [DW-1:0] q_x;
    logic signed [DW-1:0] q_y;
    logic [NUM_W-1:0]     q_num;
    logic [10:0]          rem_sh [0:N-1];

    always_comb begin
        // pre-rotate into the right half plane, set up the dividend
        q_x   = {{(DW-27){r_p_diff[10]}}, r_p_diff, 16'b0};
        q_y   = $signed({24'b0, r_p_d} * {15'b0, SQRT3_Q16});
        q_num = ((NUM_W'(r_p_sum) - NUM_W'(r_p_mn) * NUM_W'(3)) << SAT_BITS)
                + NUM_W'(r_p_sum >> 1);
        if (q_x < 0) begin
            n_x[0]   = q_y;
            n_y[0]   = -q_x;
            n_acc[0] = DEG90_Q20;
        end else begin
            n_x[0]   = q_x;
            n_y[0]   = q_y;
            n_acc[0] = '0;
        end
        n_rem[0] = 10'(q_num >> DIV_STEPS);
        n_nlo[0] = q_num[DIV_STEPS-1:0];
        n_q[0]   = '0;

        // CORDIC vectoring step per stage; one divider bit in each of the first DIV_STEPS
        for (int k = 0; k < N; k++) begin
            if (r_y[k] >= 0) begin
                n_x[k+1]   = r_x[k] + (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] - (r_x[k] >>> k);
                n_acc[k+1] = r_acc[k] + atan_deg(5'(k));
            end else begin
                n_x[k+1]   = r_x[k] - (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] + (r_x[k] >>> k);
                n_acc[k+1] = r_acc[k] - atan_deg(5'(k));
            end
            rem_sh[k]  = {r_rem[k], r_nlo[k][DIV_STEPS-1]};
            n_nlo[k+1] = r_nlo[k] << 1;
            if (k < DIV_STEPS) begin
                if (rem_sh[k] >= {1'b0, r_sum[k]}) begin
                    n_rem[k+1] = 10'(rem_sh[k] - {1'b0, r_sum[k]});
                    n_q[k+1]   = {r_q[k][DIV_STEPS-2:0], 1'b1};
                end else begin
                    n_rem[k+1] = rem_sh[k][9:0];
                    n_q[k+1]   = {r_q[k][DIV_STEPS-2:0], 1'b0};
                end
            end else begin
                n_rem[k+1] = r_rem[k];
                n_q[k+1]   = r_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= r_p_valid;
            for (int k = 0; k < N; k++) r_v[k+1] <= r_v[k];
        end
        r_sum[0]  <= r_p_sum;
        r_grey[0] <= r_p_grey;
        r_bg[0]   <= r_p_bg;
        for (int k = 0; k < N; k++) begin
            r_sum[k+1]  <= r_sum[k];
            r_grey[k+1] <= r_grey[k];
            r_bg[k+1]   <= r_bg[k];
        end
        for (int k = 0; k <= N; k++) begin
            r_x[k]   <= n_x[k];
            r_y[k]   <= n_y[k];
            r_acc[k] <= n_acc[k];
            r_rem[k] <= n_rem[k];
            r_nlo[k] <= n_nlo[k];
            r_q[k]   <= n_q[k];
        end
    end

    // clamp, round, reflect, saturate; zero hue for grey, zero saturation for black
    logic signed [DW-1:0] f_acc;
    logic signed [DW-1:0] f_rnd;
    logic [19:0]          f_ang;
    logic [19:0]          f_hue;
    logic [DIV_STEPS-1:0] f_sat;

    always_comb begin
        f_acc = r_acc[N];
        if (f_acc < 0)          f_acc = '0;
        if (f_acc > DEG180_Q20) f_acc = DEG180_Q20;
        f_rnd = (f_acc + HUE_HALF) >>> HUE_SHIFT;
        f_ang = f_rnd[19:0];
        f_hue = r_bg[N] ? HUE_FULL - f_ang : f_ang;
        if (r_grey[N]) f_hue = '0;
        f_sat = (r_q[N] > SAT_MAX) ? SAT_MAX : r_q[N];
        if (r_sum[N] == '0) f_sat = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v[N];
        end
        r_hsi.hue           <= f_hue[14:0];
        r_hsi.saturation    <= 16'(f_sat);
        r_hsi.intensity_sum <= r_sum[N];
    end

    assign o_done = r_done;
    assign o_hsi  = r_hsi;

`ifndef SYNTH
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hsi.intensity_sum == 10'd0 |-> o_hsi.saturation == 16'd0
        && o_hsi.hue == 15'd0)
        else $error("black pixel with nonzero hue or saturation");
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_hsi.hue <= 15'(HUE_FULL))
        else $error("hue out of range");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N] |=> o_done)
        else $error("result lost at output stage");
`endif

endmodule

FILE: bench/tb.sv
// Testbench for rgb_to_hsi_converter: directed table and random pixels, each
// result checked against a built-in CORDIC/divider model. Depends on rgbhsi_pkg.
`timescale 1ns / 1ps
module tb;
    import rgbhsi_pkg::*;

    localparam int LATENCY = 27;
    localparam int N_RANDOM = 1900;
    localparam int HUE_WILD = -1;   // table marker: hue not typed in, use model

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_rgb i_pixel;
    logic o_done;
    t_hsi o_hsi;

    t_hsi pending_hsi[$];
    int   mismatches;
    bit   failed;

    rgb_to_hsi_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (i_pixel),
        .o_done  (o_done),
        .o_hsi   (o_hsi)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // atan(2^-k) in degrees, Q20
    function automatic longint arctan_q20(input int k);
        longint tbl[24] = '{47185920, 27855475, 14718068, 7471121, 3750058,
            1876857, 938658, 469357, 234682, 117342, 58671, 29335, 14668,
            7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        return tbl[k];
    endfunction

    // Hue/saturation/sum of one pixel
    function automatic t_hsi hsi_of(input t_rgb px);
        t_hsi   res;
        longint r, g, b, s, mn, x, y, t, xs, ys, ang, q, num;
        r = px.red;
        g = px.green;
        b = px.blue;
        s = r + g + b;
        mn = (g < r) ? g : r;
        if (b < mn) mn = b;
        res = '0;
        res.intensity_sum = 10'(s);
        if (!(r == g && g == b)) begin
            x = (2 * r - g - b) * 65536;
            y = ((g > b) ? g - b : b - g) * 113512;
            ang = 0;
            // pre-rotate left half-plane by 90 degrees
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                ang = 94371840;
            end
            for (int k = 0; k < 24; k++) begin
                xs = x >>> k;
                ys = y >>> k;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    ang += arctan_q20(k);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    ang -= arctan_q20(k);
                end
            end
            if (ang < 0) ang = 0;
            if (ang > 188743680) ang = 188743680;
            ang = (ang + (1 << (ANG_BITS - HUE_FRAC_BITS - 1))) >>> (ANG_BITS - HUE_FRAC_BITS);
            // reflect when blue exceeds green
            res.hue = 15'((b > g) ? (360 << HUE_FRAC_BITS) - ang : ang);
        end
        if (s != 0) begin
            num = (s - 3 * mn) << SAT_BITS;
            q = (num + s / 2) / s;
            if (q > (1 << SAT_BITS) - 1) q = (1 << SAT_BITS) - 1;
            if (q > 65535) q = 65535;
            res.saturation = 16'(q);
        end
        return res;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_hsi want;
        if (i_rst_n && o_done) begin
            if (pending_hsi.size() == 0) begin
                failed <= 1'b1;
                if (mismatches < 10)
                    $display("unexpected result %h", o_hsi);
                mismatches++;
            end else begin
                want = pending_hsi.pop_front();
                if (o_hsi.hue !== want.hue || o_hsi.saturation !== want.saturation
                        || o_hsi.intensity_sum !== want.intensity_sum) begin
                    failed <= 1'b1;
                    if (mismatches < 10)
                        $display("mismatch: exp h=%0d s=%0d i=%0d got h=%0d s=%0d i=%0d",
                                 want.hue, want.saturation, want.intensity_sum,
                                 o_hsi.hue, o_hsi.saturation, o_hsi.intensity_sum);
                    mismatches++;
                end
            end
        end
    end

    // Send one request; expectation queued on acceptance
    task automatic send_pixel(input t_rgb px, input t_hsi want);
        start <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_hsi.push_back(want);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    typedef struct {
        t_rgb px;
        int   hue;
        int   sat;
    } t_row;

    // Directed rows: grey/black typed in, extremes with typed saturation and some hues, others from the model
    t_row dir_rows[] = '{
        '{'{8'd0,   8'd0,   8'd0},   0, 0},
        '{'{8'd255, 8'd255, 8'd255}, 0, 0},
        '{'{8'd128, 8'd128, 8'd128}, 0, 0},
        '{'{8'd255, 8'd0,   8'd0},   0, 65535},
        '{'{8'd0,   8'd255, 8'd0},   HUE_WILD, 65535},
        '{'{8'd0,   8'd0,   8'd255}, HUE_WILD, 65535},
        '{'{8'd255, 8'd255, 8'd0},   HUE_WILD, 65535},
        '{'{8'd0,   8'd255, 8'd255}, 11520, 65535},
        '{'{8'd255, 8'd0,   8'd255}, HUE_WILD, 65535},
        '{'{8'd1,   8'd0,   8'd0},   0, 65535},
        '{'{8'd0,   8'd1,   8'd0},   HUE_WILD, 65535},
        '{'{8'd0,   8'd0,   8'd1},   HUE_WILD, 65535},
        '{'{8'd170, 8'd85,  8'd85},  HUE_WILD, HUE_WILD},
        '{'{8'd254, 8'd255, 8'd255}, HUE_WILD, HUE_WILD},
        '{'{8'd255, 8'd254, 8'd254}, HUE_WILD, HUE_WILD},
        '{'{8'd100, 8'd50,  8'd51},  HUE_WILD, HUE_WILD},
        '{'{8'd100, 8'd51,  8'd50},  HUE_WILD, HUE_WILD},
        '{'{8'd10,  8'd200, 8'd201}, HUE_WILD, HUE_WILD}
    };

    initial begin
        t_hsi want;
        t_rgb px;
        int   wait_cnt;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_pixel = '0;
        mismatches = 0;
        failed = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            want = hsi_of(dir_rows[k].px);
            if (dir_rows[k].hue != HUE_WILD) want.hue = 15'(dir_rows[k].hue);
            if (dir_rows[k].sat != HUE_WILD) want.saturation = 16'(dir_rows[k].sat);
            send_pixel(dir_rows[k].px, want);
            idle_gap();
        end

        // Random pixels: mix of full range, near-grey and single-channel cases
        for (int k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 3))
                0: begin
                    px.red = 8'($urandom_range(0, 255));
                    px.green = 8'(int'(px.red) + $urandom_range(0, 2) - 1);
                    px.blue = 8'(int'(px.red) + $urandom_range(0, 2) - 1);
                end
                1: begin
                    px = '0;
                    px[8 * $urandom_range(0, 2) +: 8] = 8'($urandom);
                end
                default: px = t_rgb'(24'($urandom));
            endcase
            send_pixel(px, hsi_of(px));
            if ($urandom_range(0, 1) == 0) idle_gap();
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_hsi.size() != 0 && wait_cnt < 10000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (!failed && pending_hsi.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
